### rtl/srm_pkg.sv
// Shared types and constants for the step response metrics block.
// No dependencies.
package srm_pkg;
	localparam int OS_WIDTH = 24;
	localparam int OS_WHOLE_SAT = 656;
	localparam int OS_SCALE = 25600;
	localparam logic [OS_WIDTH-1:0] OS_MAX = '1;
	localparam int CFG_IDX_WIDTH = 1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_START = 1'b0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET = 1'b1;
	localparam int ONE_Q16 = 65536;
endpackage

### rtl/srm_front.sv
// Front part: per-sample tracking of crossings, peak and settling.
// Depends on srm_pkg. Emits one finished record summary per record_end.
module srm_front #(
	parameter int LW = 32,
	parameter int TW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [TW-1:0]        sample_time,
	input  logic signed [LW-1:0] sample_level,
	input  logic                 record_end,
	input  logic signed [LW-1:0] start_q,
	input  logic signed [LW-1:0] target_q,
	output logic                 rec_valid,
	output logic                 rec_short,
	output logic signed [TW:0]   rec_rise,
	output logic signed [TW:0]   rec_half,
	output logic signed [LW-1:0] rec_peak,
	output logic [TW-1:0]        rec_peak_t,
	output logic [TW-1:0]        rec_s2,
	output logic [TW-1:0]        rec_s5,
	output logic signed [LW:0]   rec_err,
	output logic signed [LW-1:0] rec_target
);
	import srm_pkg::*;
	// room for |error| * 50 plus sign
	localparam int DW = LW + 7;

	logic [1:0]           cnt_q;
	logic [TW-1:0]        first_q, pk_t_q, t10_q, t50_q, t90_q, s2_q, s5_q;
	logic signed [LW-1:0] pk_q;
	logic [2:0]           found_q;
	logic [1:0]           oob_prev_q;

	logic                 first;
	logic signed [DW-1:0] d, rel, e, ea, ta;
	logic signed [DW-1:0] pk_base;
	logic                 up;
	logic [2:0]           hit;
	logic [1:0]           oob, act;
	logic [TW-1:0]        t10_n, t50_n, t90_n, s2_n, s5_n;

	always_comb begin
		first = (cnt_q == 2'd0);
		d = DW'(target_q) - DW'(start_q);
		if (d == '0)
			d = DW'(ONE_Q16);
		rel = DW'(sample_level) - DW'(start_q);
		e = DW'(sample_level) - DW'(target_q);
		ea = e[DW-1] ? -e : e;
		ta = target_q[LW-1] ? -DW'(target_q) : DW'(target_q);
		pk_base = first ? DW'(start_q) : DW'(pk_q);
		up = DW'(sample_level) > pk_base;
		hit[0] = ((rel <<< 3) + (rel <<< 1)) >= d;
		hit[1] = (rel <<< 1) >= d;
		hit[2] = ((rel <<< 3) + (rel <<< 1)) >= ((d <<< 3) + d);
		oob[0] = ((ea <<< 5) + (ea <<< 4) + (ea <<< 1)) > ta;
		oob[1] = ((ea <<< 4) + (ea <<< 2)) > ta;
		act = oob | oob_prev_q;
		t10_n = (!found_q[0] && hit[0]) ? sample_time : t10_q;
		t50_n = (!found_q[1] && hit[1]) ? sample_time : t50_q;
		t90_n = (!found_q[2] && hit[2]) ? sample_time : t90_q;
		s2_n = act[0] ? sample_time : s2_q;
		s5_n = act[1] ? sample_time : s5_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; first_q <= '0; pk_q <= '0; pk_t_q <= '0;
			t10_q <= '0; t50_q <= '0; t90_q <= '0; found_q <= '0;
			s2_q <= '0; s5_q <= '0; oob_prev_q <= '0; rec_valid <= 1'b0;
		end else begin
			rec_valid <= take && record_end;
			if (take) begin
				if (record_end) begin
					cnt_q <= '0; first_q <= '0; pk_q <= '0; pk_t_q <= '0;
					t10_q <= '0; t50_q <= '0; t90_q <= '0; found_q <= '0;
					s2_q <= '0; s5_q <= '0; oob_prev_q <= '0;
				end else begin
					if (cnt_q != 2'd2)
						cnt_q <= cnt_q + 2'd1;
					if (first)
						first_q <= sample_time;
					pk_q <= up ? sample_level : LW'(pk_base);
					if (up)
						pk_t_q <= first ? '0 : sample_time;
					else if (first)
						pk_t_q <= '0;
					t10_q <= t10_n; t50_q <= t50_n; t90_q <= t90_n;
					found_q <= found_q | hit;
					s2_q <= s2_n; s5_q <= s5_n;
					oob_prev_q <= oob;
				end
			end
		end
	end

	// record summary, payload only
	always_ff @(posedge clk) begin
		if (take && record_end) begin
			rec_short <= first;
			rec_rise <= (((found_q | hit) & 3'b101) == 3'b101) ?
				(TW+1)'({1'b0, t90_n}) - (TW+1)'({1'b0, t10_n}) : '0;
			rec_half <= (found_q[1] || hit[1]) ?
				(TW+1)'({1'b0, t50_n}) - (TW+1)'({1'b0, first_q}) : '0;
			rec_peak <= up ? sample_level : LW'(pk_base);
			rec_peak_t <= up ? sample_time : pk_t_q;
			rec_s2 <= s2_n;
			rec_s5 <= s5_n;
			rec_err <= (LW+1)'(sample_level) - (LW+1)'(target_q);
			rec_target <= target_q;
		end
	end
endmodule

### rtl/srm_fifo.sv
// Short queue of finished record summaries between front and back.
// Depends on srm_pkg only through its users; plain storage.
module srm_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] dout
);
	logic [W-1:0] mem_q [4];
	logic [1:0]   wp_q, rp_q;
	logic [2:0]   n_q;

	assign empty = (n_q == 3'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; n_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 2'd1;
			if (pop)
				rp_q <= rp_q + 2'd1;
			n_q <= n_q + 3'(push) - 3'(pop);
		end
	end
endmodule

### rtl/srm_back.sv
// Back part: overshoot percentage by restoring division, then result strobe.
// Depends on srm_pkg.
module srm_back #(
	parameter int LW = 32,
	parameter int TW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 have,
	output logic                 pop,
	input  logic                 in_short,
	input  logic signed [TW:0]   in_rise,
	input  logic signed [TW:0]   in_half,
	input  logic signed [LW-1:0] in_peak,
	input  logic [TW-1:0]        in_peak_t,
	input  logic [TW-1:0]        in_s2,
	input  logic [TW-1:0]        in_s5,
	input  logic signed [LW:0]   in_err,
	input  logic signed [LW-1:0] in_target,
	output logic                 done,
	output logic signed [TW:0]   rise_span,
	output logic signed [TW:0]   half_delay,
	output logic signed [LW-1:0] peak_level,
	output logic [TW-1:0]        peak_stamp,
	output logic [srm_pkg::OS_WIDTH-1:0] overshoot_percent,
	output logic [TW-1:0]        settle_two_stamp,
	output logic [TW-1:0]        settle_five_stamp,
	output logic signed [LW:0]   final_error,
	output logic                 short_record
);
	import srm_pkg::*;
	// quotient of num*25600/den; saturates when num >= 656*den or the quotient exceeds 24 bits
	localparam int NW = LW + 16;
	localparam int CW = $clog2(NW + 1);
	typedef enum logic [1:0] {IDLE, DIV, FIN} st_t;

	st_t           st_q;
	logic [NW-1:0] num_q, rem_q;
	logic [LW:0]   den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          sat_q, zero_q;

	logic signed [LW:0] diff;
	logic [LW:0]        den_c, numd;
	logic [NW:0]        trial;
	logic [NW-1:0]      scaled;

	always_comb begin
		diff = (LW+1)'(in_peak) - (LW+1)'(in_target);
		den_c = in_target[LW-1] ? -(LW+1)'(in_target) : (LW+1)'(in_target);
		numd = diff;
		scaled = NW'(numd) * NW'(OS_SCALE);
		trial = {rem_q, num_q[NW-1]} - (NW+1)'(den_q);
	end

	assign pop = have && (st_q == IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE; done <= 1'b0; cnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				IDLE: begin
					if (have) begin
						rise_span <= in_rise; half_delay <= in_half;
						peak_level <= in_peak; peak_stamp <= in_peak_t;
						settle_two_stamp <= in_s2; settle_five_stamp <= in_s5;
						final_error <= in_err; short_record <= in_short;
						zero_q <= in_short || in_target == '0 || diff <= 0;
						sat_q <= (NW+1)'(numd) >= (NW+1)'(den_c) * (NW+1)'(OS_WHOLE_SAT);
						num_q <= scaled; den_q <= den_c;
						rem_q <= '0; quo_q <= '0;
						cnt_q <= CW'(NW);
						st_q <= DIV;
					end
				end
				DIV: begin
					if (trial[NW]) begin
						rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end else begin
						rem_q <= trial[NW-1:0];
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end
					num_q <= num_q << 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1))
						st_q <= FIN;
				end
				FIN: begin
					if (zero_q)
						overshoot_percent <= '0;
					else if (sat_q || quo_q > NW'(OS_MAX))
						overshoot_percent <= OS_MAX;
					else
						overshoot_percent <= quo_q[OS_WIDTH-1:0];
					// queue head has already moved on; use the captured flag
					if (short_record) begin
						rise_span <= '0; half_delay <= '0; peak_level <= '0;
						peak_stamp <= '0; settle_two_stamp <= '0;
						settle_five_stamp <= '0; final_error <= '0;
					end
					done <= 1'b1;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

### rtl/step_response_metrics.sv
// Step response metrics: one sample per cycle in, one result per record out.
// A record_end passes the front registers, the record queue and the bit-serial
// overshoot divider in the back part before done; the divider finishes one record
// before it takes another from the queue. Samples are taken every cycle with start high while
// fewer than four finished records wait for the back part; busy is high otherwise.
// Reset: asynchronous; control and record state clear to zero, data outputs do not.
module step_response_metrics #(
	parameter int LEVEL_WIDTH = 32,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [srm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [LEVEL_WIDTH-1:0]        cfg_data,
	input  logic [TIME_WIDTH-1:0]         sample_time,
	input  logic signed [LEVEL_WIDTH-1:0] sample_level,
	input  logic                          record_end,
	output logic                          done,
	output logic signed [TIME_WIDTH:0]    rise_span,
	output logic signed [TIME_WIDTH:0]    half_delay,
	output logic signed [LEVEL_WIDTH-1:0] peak_level,
	output logic [TIME_WIDTH-1:0]         peak_stamp,
	output logic [srm_pkg::OS_WIDTH-1:0]  overshoot_percent,
	output logic [TIME_WIDTH-1:0]         settle_two_stamp,
	output logic [TIME_WIDTH-1:0]         settle_five_stamp,
	output logic signed [LEVEL_WIDTH:0]   final_error,
	output logic                          short_record
);
	import srm_pkg::*;
	localparam int LW = LEVEL_WIDTH;
	localparam int TW = TIME_WIDTH;
	localparam int QW = 1 + 2*(TW+1) + LW + 3*TW + (LW+1) + LW;

	logic signed [LW-1:0] start_q, target_q;
	logic                 take, rv, rs, pop, empty;
	logic signed [TW:0]   rr, rh;
	logic signed [LW-1:0] rp, rt;
	logic [TW-1:0]        rpt, r2, r5;
	logic signed [LW:0]   re;
	logic [QW-1:0]        qin, qout;
	logic [2:0]           inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0; target_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START:  start_q <= cfg_data;
				REG_TARGET: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// count records taken at the front but not yet popped by the back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 3'(take && record_end) - 3'(pop);
	end

	assign busy = (inflight_q >= 3'd4);
	assign take = start && !busy;

	srm_front #(.LW(LW), .TW(TW)) u_front (
		.clk, .arst_n, .take, .sample_time, .sample_level, .record_end,
		.start_q, .target_q, .rec_valid(rv), .rec_short(rs), .rec_rise(rr),
		.rec_half(rh), .rec_peak(rp), .rec_peak_t(rpt), .rec_s2(r2),
		.rec_s5(r5), .rec_err(re), .rec_target(rt)
	);

	assign qin = {rs, rr, rh, rp, rpt, r2, r5, re, rt};

	srm_fifo #(.W(QW)) u_fifo (
		.clk, .arst_n, .push(rv), .din(qin), .pop, .empty, .dout(qout)
	);

	logic                 q_s;
	logic signed [TW:0]   q_r, q_h;
	logic signed [LW-1:0] q_p, q_t;
	logic [TW-1:0]        q_pt, q_2, q_5;
	logic signed [LW:0]   q_e;
	assign {q_s, q_r, q_h, q_p, q_pt, q_2, q_5, q_e, q_t} = qout;

	srm_back #(.LW(LW), .TW(TW)) u_back (
		.clk, .arst_n, .have(!empty), .pop,
		.in_short(q_s), .in_rise(q_r), .in_half(q_h), .in_peak(q_p),
		.in_peak_t(q_pt), .in_s2(q_2), .in_s5(q_5), .in_err(q_e),
		.in_target(q_t), .done, .rise_span, .half_delay, .peak_level,
		.peak_stamp, .overshoot_percent, .settle_two_stamp, .settle_five_stamp,
		.final_error, .short_record
	);
endmodule
